### rtl/midpoint_line_rasterizer_assert.svh
// Assertion macros used by the line rasterizer top level.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define MLR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MLR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MLR_ASSERT(lbl, clk, rstn, prop, msg)
`define MLR_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/mlr_pkg.sv
// Types and constants shared by the midpoint line rasterizer.
package mlr_pkg;

  localparam int COORD_BITS = 6;
  // The decision variable is signed and three bits wider than a coordinate.
  localparam int DEC_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef enum logic [2:0] {
    SC_VERT      = 3'd0,
    SC_HORZ      = 3'd1,
    SC_GENTLE_UP = 3'd2,
    SC_STEEP_UP  = 3'd3,
    SC_GENTLE_DN = 3'd4,
    SC_STEEP_DN  = 3'd5
  } slope_e;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t stop_x;
    coord_t stop_y;
    dec_t   decision;
    dec_t   inc_a;
    dec_t   inc_b;
    slope_e slope;
  } line_state_t;

  typedef struct packed {
    coord_t next_x;
    coord_t next_y;
    dec_t   next_decision;
    logic   at_end;
  } step_t;

endpackage

### rtl/mlr_setup.sv
// Endpoint ordering, slope classification and decision variable setup.
module mlr_setup (
  input  mlr_pkg::coord_t      start_x_i,
  input  mlr_pkg::coord_t      start_y_i,
  input  mlr_pkg::coord_t      end_x_i,
  input  mlr_pkg::coord_t      end_y_i,
  output mlr_pkg::line_state_t init_o
);
  import mlr_pkg::*;

  coord_t                 ax, ay, bx, by;
  logic [COORD_BITS-1:0]  dx;
  logic [COORD_BITS:0]    dy_raw;
  dec_t                   dxs, dys;
  logic                   swap;

  always_comb begin
    swap = (start_x_i > end_x_i);
    ax = swap ? end_x_i   : start_x_i;
    ay = swap ? end_y_i   : start_y_i;
    bx = swap ? start_x_i : end_x_i;
    by = swap ? start_y_i : end_y_i;
    dx     = bx - ax;
    dy_raw = {1'b0, by} - {1'b0, ay};
    dxs = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, dx});
    dys = $signed({{(DEC_BITS-COORD_BITS-1){dy_raw[COORD_BITS]}}, dy_raw});

    init_o.cur_x    = ax;
    init_o.cur_y    = ay;
    init_o.stop_x   = bx;
    init_o.stop_y   = by;
    init_o.decision = '0;
    init_o.inc_a    = '0;
    init_o.inc_b    = '0;

    if (dxs == '0) begin
      init_o.slope = SC_VERT;
      // Vertical lines always walk upward in y.
      if (ay > by) begin
        init_o.cur_y  = by;
        init_o.stop_y = ay;
      end
    end else if (dys == '0) begin
      init_o.slope = SC_HORZ;
    end else if (dys > 0 && dxs >= dys) begin
      init_o.slope    = SC_GENTLE_UP;
      init_o.decision = (dys <<< 1) - dxs;
      init_o.inc_a    = dys <<< 1;
      init_o.inc_b    = (dys - dxs) <<< 1;
    end else if (dys > 0) begin
      init_o.slope    = SC_STEEP_UP;
      init_o.decision = (dxs <<< 1) - dys;
      init_o.inc_a    = dxs <<< 1;
      init_o.inc_b    = (dxs - dys) <<< 1;
    end else if (dxs >= -dys) begin
      init_o.slope    = SC_GENTLE_DN;
      init_o.decision = (dys <<< 1) + dxs;
      init_o.inc_a    = dys <<< 1;
      init_o.inc_b    = (dys + dxs) <<< 1;
    end else begin
      init_o.slope    = SC_STEEP_DN;
      init_o.decision = (dxs <<< 1) + dys;
      init_o.inc_a    = dxs <<< 1;
      init_o.inc_b    = (dxs + dys) <<< 1;
    end
  end

endmodule

### rtl/mlr_step.sv
// Shared step unit: one decision adder and the coordinate updates for one pixel.
module mlr_step (
  input  mlr_pkg::line_state_t line_i,
  output mlr_pkg::step_t       step_o
);
  import mlr_pkg::*;

  logic straight;

  always_comb begin
    case (line_i.slope)
      SC_GENTLE_DN: straight = (line_i.decision > 0);
      default:      straight = (line_i.decision <= 0);
    endcase

    step_o.next_decision = line_i.decision + (straight ? line_i.inc_a : line_i.inc_b);
    step_o.next_x = line_i.cur_x;
    step_o.next_y = line_i.cur_y;

    case (line_i.slope)
      SC_VERT: begin
        step_o.next_y = line_i.cur_y + 1'b1;
      end
      SC_HORZ: begin
        step_o.next_x = line_i.cur_x + 1'b1;
      end
      SC_GENTLE_UP: begin
        step_o.next_x = line_i.cur_x + 1'b1;
        if (!straight) step_o.next_y = line_i.cur_y + 1'b1;
      end
      SC_STEEP_UP: begin
        step_o.next_y = line_i.cur_y + 1'b1;
        if (!straight) step_o.next_x = line_i.cur_x + 1'b1;
      end
      SC_GENTLE_DN: begin
        step_o.next_x = line_i.cur_x + 1'b1;
        if (!straight) step_o.next_y = line_i.cur_y - 1'b1;
      end
      default: begin
        step_o.next_y = line_i.cur_y - 1'b1;
        if (!straight) step_o.next_x = line_i.cur_x + 1'b1;
      end
    endcase

    // Steep and vertical lines finish on y, the others on x.
    if (line_i.slope inside {SC_VERT, SC_STEEP_UP, SC_STEEP_DN}) begin
      step_o.at_end = (line_i.cur_y == line_i.stop_y);
    end else begin
      step_o.at_end = (line_i.cur_x == line_i.stop_x);
    end
  end

endmodule

### rtl/midpoint_line_rasterizer.sv
// Top level of the midpoint line rasterizer: sequencer and line state.
//
// A request is taken when start_i is high and busy_o is low. The endpoints
// are ordered so x never decreases, and the line's pixels then come out one
// per clock cycle, starting the cycle after the request, each beat marked by
// pixel_strobe_o for one cycle; last_pixel_o marks the final beat. The receiver
// cannot stall the output. A line has n = max(|dx|, |dy|) + 1 pixels, from 1
// to 64; busy_o stays high while it is drawn, so a new request can only be
// taken once its last pixel is out. The walk runs on one shared step unit that
// makes one decision update and one pixel move per cycle.
module midpoint_line_rasterizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  mlr_pkg::coord_t start_x_i,
  input  mlr_pkg::coord_t start_y_i,
  input  mlr_pkg::coord_t end_x_i,
  input  mlr_pkg::coord_t end_y_i,
  output logic            pixel_strobe_o,
  output mlr_pkg::coord_t pixel_x_o,
  output mlr_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);
  import mlr_pkg::*;
  `include "midpoint_line_rasterizer_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e      state_q, state_d;
  line_state_t line_q, line_d;
  line_state_t init;
  step_t       step;
  logic        accept;

  mlr_setup u_setup (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .init_o    (init)
  );

  mlr_step u_step (
    .line_i (line_q),
    .step_o (step)
  );

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          line_d  = init;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step.at_end) begin
          state_d = ST_IDLE;
        end else begin
          line_d.cur_x    = step.next_x;
          line_d.cur_y    = step.next_y;
          line_d.decision = step.next_decision;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      line_q  <= '0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign pixel_strobe_o = (state_q == ST_EMIT);
  assign pixel_x_o      = line_q.cur_x;
  assign pixel_y_o      = line_q.cur_y;
  assign last_pixel_o   = (state_q == ST_EMIT) && step.at_end;

  `MLR_ASSERT(a_accept_emits, clk_i, rst_ni,
    (start_i && !busy_o) |=> pixel_strobe_o, "request did not start a line")
  `MLR_ASSERT(a_last_frees, clk_i, rst_ni,
    (pixel_strobe_o && last_pixel_o) |=> !busy_o, "block stayed busy after last pixel")
  `MLR_ASSERT(a_no_gap, clk_i, rst_ni,
    (pixel_strobe_o && !last_pixel_o) |=> pixel_strobe_o, "gap inside a line")
  `MLR_ASSERT(a_x_monotonic, clk_i, rst_ni,
    (pixel_strobe_o && !last_pixel_o) |=> (pixel_x_o >= $past(pixel_x_o)),
    "x decreased along a line")
  `MLR_ASSERT_NEVER(a_strobe_busy, clk_i, rst_ni,
    pixel_strobe_o && !busy_o, "pixel beat while idle")

endmodule
